// ===== rtl/core/ztcp_pkg.sv =====
// shared types and constants for the depth-buffer tile copy planner
// no dependencies
package ztcp_pkg;

  localparam int TILE_BYTES = 2048;
  localparam int TILE_LOG = $clog2(TILE_BYTES);
  localparam int SEG_BYTES_W = 12;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_FORMAT      = 4'd1,
    ST_COMPRESSED  = 4'd2,
    ST_MULTISAMPLE = 4'd3,
    ST_ALIGNMENT   = 4'd4,
    ST_PITCH       = 4'd5,
    ST_BOUNDS      = 4'd6,
    ST_BUFFER      = 4'd7,
    ST_OVERLAP     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    CFG_SRC_BUFFER_BYTES = 3'd0,
    CFG_DST_BUFFER_BYTES = 3'd1,
    CFG_SRC_MACRO_WIDTH  = 3'd2,
    CFG_SRC_MACRO_HEIGHT = 3'd3,
    CFG_SRC_MACRO_PITCH  = 3'd4,
    CFG_DST_MACRO_WIDTH  = 3'd5,
    CFG_DST_MACRO_HEIGHT = 3'd6,
    CFG_DST_MACRO_PITCH  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic [15:0] src_tile_x;
    logic [15:0] src_tile_y;
    logic [15:0] dst_tile_x;
    logic [15:0] dst_tile_y;
    logic        formats_match;
    logic        is_compressed;
    logic        is_multisample;
    logic        shared_buffer;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] seg_src_offset;
    logic [31:0] seg_dst_offset;
    logic [11:0] seg_bytes;
    logic        last;
  } seg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic        x_par;
    logic        y_par;
  } plan_t;

  typedef struct packed {
    logic [31:0] src_buffer_bytes;
    logic [31:0] dst_buffer_bytes;
    logic [15:0] src_macro_width;
    logic [15:0] src_macro_height;
    logic [15:0] src_macro_pitch;
    logic [15:0] dst_macro_width;
    logic [15:0] dst_macro_height;
    logic [15:0] dst_macro_pitch;
  } cfg_t;

endpackage

// ===== rtl/core/zbuffer_tile_copy_planner_top.sv =====
// A request is registered and checked in the front stage, waits in a two-entry
// queue, and the back stage then sends one result per cycle from the queue head
// into an output register, unless seg_stall holds that register. A refused
// request gives one result and an accepted plan 1, 2 or 4, and that back stage
// sets the sustained rate, while the front keeps taking requests until the
// queue fills. A request passes the front register, a queue slot and the output
// register before its first result. Depends on ztcp_pkg and the ztcp_* modules.
module zbuffer_tile_copy_planner_top import ztcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        seg_valid,
  input  logic        seg_stall,
  output seg_t        seg
);

  logic  plan_push;
  logic  plan_full;
  plan_t plan;
  logic  head_valid;
  plan_t head;
  logic  pop;

  ztcp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .plan_valid (plan_push),
    .plan_full  (plan_full),
    .plan       (plan)
  );

  ztcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (plan_push),
    .push_data  (plan),
    .full       (plan_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ztcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg)
  );

endmodule

// ===== rtl/core/ztcp_front.sv =====
// front stage: configuration registers, request checks and classification
// depends on ztcp_pkg
module ztcp_front import ztcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        plan_valid,
  input  logic        plan_full,
  output plan_t       plan
);

  cfg_t    cfg;
  logic    fvalid;
  logic    fvalid_next;
  logic    accept;
  logic    push;
  logic    mis_s, mis_d, pitch_bad, bounds_bad, buf_bad_s, buf_bad_d;
  logic    side_fail, overlap;
  status_t status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_BUFFER_BYTES: cfg.src_buffer_bytes <= cfg_data;
        CFG_DST_BUFFER_BYTES: cfg.dst_buffer_bytes <= cfg_data;
        CFG_SRC_MACRO_WIDTH:  cfg.src_macro_width  <= cfg_data[15:0];
        CFG_SRC_MACRO_HEIGHT: cfg.src_macro_height <= cfg_data[15:0];
        CFG_SRC_MACRO_PITCH:  cfg.src_macro_pitch  <= cfg_data[15:0];
        CFG_DST_MACRO_WIDTH:  cfg.dst_macro_width  <= cfg_data[15:0];
        CFG_DST_MACRO_HEIGHT: cfg.dst_macro_height <= cfg_data[15:0];
        CFG_DST_MACRO_PITCH:  cfg.dst_macro_pitch  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mis_s = req.src_offset[TILE_LOG-1:0] != '0;
    mis_d = req.dst_offset[TILE_LOG-1:0] != '0;
    pitch_bad = (cfg.src_macro_pitch < cfg.src_macro_width) ||
                (cfg.dst_macro_pitch < cfg.dst_macro_width);
    bounds_bad = (cfg.src_macro_width == '0) || (cfg.src_macro_height == '0) ||
                 (cfg.dst_macro_width == '0) || (cfg.dst_macro_height == '0) ||
                 (req.src_tile_x >= cfg.src_macro_width) ||
                 (req.src_tile_y >= cfg.src_macro_height) ||
                 (req.dst_tile_x >= cfg.dst_macro_width) ||
                 (req.dst_tile_y >= cfg.dst_macro_height);
    buf_bad_s = ({1'b0, req.src_offset} + 33'(TILE_BYTES)) > {1'b0, cfg.src_buffer_bytes};
    buf_bad_d = ({1'b0, req.dst_offset} + 33'(TILE_BYTES)) > {1'b0, cfg.dst_buffer_bytes};
    side_fail = mis_s || mis_d || pitch_bad || bounds_bad || buf_bad_s || buf_bad_d;
    overlap = req.shared_buffer &&
              ({1'b0, req.src_offset} < ({1'b0, req.dst_offset} + 33'(TILE_BYTES))) &&
              ({1'b0, req.dst_offset} < ({1'b0, req.src_offset} + 33'(TILE_BYTES)));
    if (!req.formats_match) begin
      status_next = ST_FORMAT;
    end else if (req.is_compressed) begin
      status_next = ST_COMPRESSED;
    end else if (req.is_multisample) begin
      status_next = ST_MULTISAMPLE;
    end else if (side_fail) begin
      if (mis_s || mis_d) begin
        status_next = ST_ALIGNMENT;
      end else if (pitch_bad) begin
        status_next = ST_PITCH;
      end else if (bounds_bad) begin
        status_next = ST_BOUNDS;
      end else begin
        status_next = ST_BUFFER;
      end
    end else if (overlap) begin
      status_next = ST_OVERLAP;
    end else begin
      status_next = ST_OK;
    end
  end

  assign push = fvalid && !plan_full;
  assign req_stall = fvalid && plan_full;
  assign accept = req_valid && !req_stall;
  assign fvalid_next = accept || (fvalid && !push);
  assign plan_valid = push;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= fvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan.status     <= status_next;
      plan.src_offset <= req.src_offset;
      plan.dst_offset <= req.dst_offset;
      plan.x_par      <= req.src_tile_x[0] ^ req.dst_tile_x[0];
      plan.y_par      <= req.src_tile_y[0] ^ req.dst_tile_y[0];
    end
  end

endmodule

// ===== rtl/core/ztcp_queue.sv =====
// short queue of classified plans between the front and back stages
// depends on ztcp_pkg
module ztcp_queue import ztcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  plan_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output plan_t head
);

  plan_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head = slots[rd_ptr];
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ztcp_back.sv =====
// back stage: walks the segments of the head plan into the result register
// depends on ztcp_pkg
module ztcp_back import ztcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  plan_t head,
  output logic  pop,
  output logic  seg_valid,
  input  logic  seg_stall,
  output seg_t  seg
);

  logic [1:0]            idx;
  logic [1:0]            last_idx;
  logic                  emit;
  logic                  is_last;
  logic [TILE_LOG-1:0]   seg_off;
  logic [TILE_LOG-1:0]   xr;
  logic [SEG_BYTES_W-1:0] nbytes;
  seg_t                  seg_next;

  always_comb begin
    xr = {head.x_par, head.y_par, (TILE_LOG - 2)'(0)};
    if (head.y_par) begin
      last_idx = 2'd3;
      seg_off = {idx, (TILE_LOG - 2)'(0)};
      nbytes = SEG_BYTES_W'(TILE_BYTES / 4);
    end else if (head.x_par) begin
      last_idx = 2'd1;
      seg_off = {idx[0], (TILE_LOG - 1)'(0)};
      nbytes = SEG_BYTES_W'(TILE_BYTES / 2);
    end else begin
      last_idx = 2'd0;
      seg_off = '0;
      nbytes = SEG_BYTES_W'(TILE_BYTES);
    end
    if (head.status != ST_OK) begin
      is_last = 1'b1;
      seg_next = '{status: head.status, seg_src_offset: '0, seg_dst_offset: '0,
                   seg_bytes: '0, last: 1'b1};
    end else begin
      is_last = idx == last_idx;
      seg_next.status = ST_OK;
      seg_next.seg_src_offset = head.src_offset + 32'(seg_off);
      seg_next.seg_dst_offset = head.dst_offset + 32'(seg_off ^ xr);
      seg_next.seg_bytes = nbytes;
      seg_next.last = is_last;
    end
  end

  assign emit = head_valid && (!seg_valid || !seg_stall);
  assign pop = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (emit) begin
        seg_valid <= 1'b1;
        idx <= is_last ? '0 : idx + 1'b1;
      end else if (!seg_stall) begin
        seg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg <= seg_next;
    end
  end

endmodule

// ===== rtl/core/ztcp_checker.sv =====
// port-level checks on the planner top, attached by bind
// depends on ztcp_pkg and zbuffer_tile_copy_planner_top
module ztcp_checker import ztcp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        seg_valid,
  input logic        seg_stall,
  input seg_t        seg
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("stalled result changed");

  // refusal is a single zero result
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.status != ST_OK |->
      seg.last && seg.seg_bytes == '0 && seg.seg_src_offset == '0 &&
      seg.seg_dst_offset == '0)
    else $error("malformed refusal");

  // plan segments have a legal size, a whole tile only as the last one
  a_seg_size: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.status == ST_OK |->
      (seg.seg_bytes == 12'(TILE_BYTES) && seg.last) ||
      seg.seg_bytes == 12'(TILE_BYTES / 2) || seg.seg_bytes == 12'(TILE_BYTES / 4))
    else $error("bad segment size");

endmodule

bind zbuffer_tile_copy_planner_top ztcp_checker u_ztcp_checker (.*);
